/* src/lnc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnc_pkg
// Shared types, constants and lookup tables of the LFSR noise channel.
// ----------------------------------------------------------------------------
package lnc_pkg;

  localparam int TICKS_W          = 10;
  localparam int TICKS_MAX        = 1023;
  localparam logic [TICKS_W-1:0] TICKS_RESET = 10'd20;
  localparam int PERIOD_SCALE_DEF = 1;
  localparam int PERIOD_MAX       = 4068;
  localparam int BASE_W           = 12;
  localparam int LFSR_W           = 15;
  localparam logic [LFSR_W-1:0] LFSR_RESET = 15'd1;
  localparam int LEN_W            = 8;
  localparam int VOL_W            = 4;
  localparam logic [VOL_W-1:0] VOL_MAX = 4'd15;
  localparam int SAMPLE_W         = 3;
  localparam int QDEPTH           = 2;
  localparam int QPTR_W           = 1;

  typedef enum logic [1:0] {
    OP_REG_WRITE = 2'd0,
    OP_ENABLE    = 2'd1,
    OP_FRAME     = 2'd2,
    OP_TICK      = 2'd3
  } op_t;

  localparam logic [1:0] REG_CTRL   = 2'd0;
  localparam logic [1:0] REG_UNUSED = 2'd1;
  localparam logic [1:0] REG_PERIOD = 2'd2;
  localparam logic [1:0] REG_LENGTH = 2'd3;

  typedef enum logic [2:0] {
    K_CTRL   = 3'd0,
    K_NOP    = 3'd1,
    K_PERIOD = 3'd2,
    K_LENGTH = 3'd3,
    K_ENABLE = 3'd4,
    K_FRAME  = 3'd5,
    K_TICK   = 3'd6
  } kind_t;

  // data holds the written byte, the enable in bit 0, or {half, quarter}.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } cmd_t;

  function automatic logic [BASE_W-1:0] period_base(input logic [3:0] sel);
    logic [BASE_W-1:0] r;
    case (sel)
      4'd0:    r = 12'd4;
      4'd1:    r = 12'd8;
      4'd2:    r = 12'd16;
      4'd3:    r = 12'd32;
      4'd4:    r = 12'd64;
      4'd5:    r = 12'd96;
      4'd6:    r = 12'd128;
      4'd7:    r = 12'd160;
      4'd8:    r = 12'd202;
      4'd9:    r = 12'd254;
      4'd10:   r = 12'd380;
      4'd11:   r = 12'd508;
      4'd12:   r = 12'd762;
      4'd13:   r = 12'd1016;
      4'd14:   r = 12'd2034;
      default: r = 12'd4068;
    endcase
    return r;
  endfunction

  function automatic logic [LEN_W-1:0] length_lookup(input logic [4:0] idx);
    logic [LEN_W-1:0] r;
    case (idx)
      5'd0:  r = 8'd10;   5'd1:  r = 8'd254;  5'd2:  r = 8'd20;   5'd3:  r = 8'd2;
      5'd4:  r = 8'd40;   5'd5:  r = 8'd4;    5'd6:  r = 8'd80;   5'd7:  r = 8'd6;
      5'd8:  r = 8'd160;  5'd9:  r = 8'd8;    5'd10: r = 8'd60;   5'd11: r = 8'd10;
      5'd12: r = 8'd14;   5'd13: r = 8'd12;   5'd14: r = 8'd26;   5'd15: r = 8'd14;
      5'd16: r = 8'd12;   5'd17: r = 8'd16;   5'd18: r = 8'd24;   5'd19: r = 8'd18;
      5'd20: r = 8'd48;   5'd21: r = 8'd20;   5'd22: r = 8'd96;   5'd23: r = 8'd22;
      5'd24: r = 8'd192;  5'd25: r = 8'd24;   5'd26: r = 8'd72;   5'd27: r = 8'd26;
      5'd28: r = 8'd16;   5'd29: r = 8'd28;   5'd30: r = 8'd32;
      default: r = 8'd30;
    endcase
    return r;
  endfunction

  // Output amplitude, floor(level * 2 / 5).
  function automatic logic [SAMPLE_W-1:0] amp_of(input logic [VOL_W-1:0] level);
    logic [SAMPLE_W-1:0] r;
    case (level)
      4'd0, 4'd1, 4'd2:         r = 3'd0;
      4'd3, 4'd4:               r = 3'd1;
      4'd5, 4'd6, 4'd7:         r = 3'd2;
      4'd8, 4'd9:               r = 3'd3;
      4'd10, 4'd11, 4'd12:      r = 3'd4;
      4'd13, 4'd14:             r = 3'd5;
      default:                  r = 3'd6;
    endcase
    return r;
  endfunction

endpackage

/* src/lnc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnc_front
// Takes input requests and classifies them into channel commands.
// ----------------------------------------------------------------------------
module lnc_front
  import lnc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // write_value[7:0], channel_enable, quarter_frame,
                                     // half_frame, zero fill
  input  logic [3:0]  s_axis_tuser,  // operation[1:0], reg_index[3:2]
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output cmd_t        cmd
);

  op_t   op;
  cmd_t  decoded;
  logic  take;

  assign op            = op_t'(s_axis_tuser[1:0]);
  assign s_axis_tready = !cmd_valid || cmd_ready;
  assign take          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    decoded.data = s_axis_tdata[7:0];
    decoded.kind = K_NOP;
    case (op)
      OP_REG_WRITE: begin
        case (s_axis_tuser[3:2])
          REG_CTRL:   decoded.kind = K_CTRL;
          REG_PERIOD: decoded.kind = K_PERIOD;
          REG_LENGTH: decoded.kind = K_LENGTH;
          default:    decoded.kind = K_NOP;
        endcase
      end
      OP_ENABLE: begin
        decoded.kind = K_ENABLE;
        decoded.data = {7'd0, s_axis_tdata[8]};
      end
      OP_FRAME: begin
        decoded.kind = K_FRAME;
        decoded.data = {6'd0, s_axis_tdata[10], s_axis_tdata[9]};
      end
      default: begin
        decoded.kind = K_TICK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (take) begin
      cmd_valid <= 1'b1;
    end else if (cmd_ready) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd <= decoded;
    end
  end

endmodule

/* src/lnc_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnc_queue
// Short command queue between the front and the back of the channel.
// ----------------------------------------------------------------------------
module lnc_queue
  import lnc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  cmd_t in_cmd,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t out_cmd
);

  cmd_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;
  logic              pop;

  assign in_ready  = count != (QPTR_W+1)'(QDEPTH);
  assign out_valid = count != '0;
  assign out_cmd   = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_cmd;
    end
  end

endmodule

/* src/lnc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnc_back
// Carries out channel commands: registers, envelope, length counter, and the
// period timer with its restoring modulo unit and the noise shift register.
// ----------------------------------------------------------------------------
module lnc_back
  import lnc_pkg::*;
#(
  parameter int PERIOD_SCALE = PERIOD_SCALE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [TICKS_W-1:0] ticks_per_sample,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  cmd_t               cmd,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [7:0]         m_axis_tdata   // sample[2:0], length_active, zero fill
);

  localparam int MAX_P   = PERIOD_SCALE * PERIOD_MAX;
  localparam int TIMER_W = $clog2(MAX_P);
  localparam int P_W     = $clog2(MAX_P + 1);
  localparam int SUM_W   = $clog2(MAX_P + TICKS_MAX);
  // The smallest period is 4, so quotient bits above SUM_W-3 are always zero.
  localparam int QW      = SUM_W - 2;
  localparam int CNT_W   = $clog2(QW);
  localparam int D_W     = P_W + QW - 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t               state;
  logic [LFSR_W-1:0]    lfsr;
  logic [TIMER_W-1:0]   timer_count;
  logic [LEN_W-1:0]     length_count;
  logic [VOL_W-1:0]     envelope_level;
  logic [VOL_W-1:0]     envelope_divider;
  logic [VOL_W-1:0]     volume_setting;
  logic                 loop_halt;
  logic                 constant_volume;
  logic                 short_mode;
  logic [3:0]           period_select;
  logic                 channel_on;

  logic [SUM_W-1:0]     rem;
  logic [D_W-1:0]       dvs;
  logic [CNT_W-1:0]     cnt;
  logic                 pend_tick;
  logic [SAMPLE_W-1:0]  pend_sample;
  logic [SAMPLE_W-1:0]  out_sample;
  logic                 out_active;

  logic                 out_free;
  logic                 pop;
  logic                 out_load;
  logic [3:0]           p_sel;
  logic [P_W-1:0]       p_load;
  logic [VOL_W-1:0]     level;
  logic [SAMPLE_W-1:0]  tick_sample;
  logic [LEN_W-1:0]     length_next;
  logic [VOL_W-1:0]     env_level_next;
  logic [VOL_W-1:0]     env_div_next;
  logic                 rem_ge;
  logic                 wrapped;
  logic [LFSR_W-1:0]    lfsr_next;
  logic                 fb;

  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign cmd_ready = (state == ST_IDLE) && out_free;
  assign pop       = cmd_valid && cmd_ready;

  // A result is loaded right at the pop for simple commands, or when the
  // modulo unit has finished for ticks and period writes.
  assign out_load = (pop && cmd.kind != K_PERIOD && cmd.kind != K_TICK) ||
                    (state == ST_DONE && out_free);

  assign m_axis_tdata = {4'd0, out_active, out_sample};

  assign p_sel  = (cmd.kind == K_PERIOD) ? cmd.data[3:0] : period_select;
  assign p_load = P_W'(PERIOD_SCALE * int'(period_base(p_sel)));

  assign level       = constant_volume ? volume_setting : envelope_level;
  assign tick_sample = (lfsr[0] && channel_on && length_count != '0) ? amp_of(level) : '0;

  assign rem_ge  = {{(D_W-SUM_W){1'b0}}, rem} >= dvs;
  assign wrapped = rem < {{(SUM_W-TICKS_W){1'b0}}, ticks_per_sample};

  assign fb        = lfsr[0] ^ (short_mode ? lfsr[6] : lfsr[1]);
  assign lfsr_next = {fb, lfsr[LFSR_W-1:1]};

  // Next length, envelope level and divider for the command being popped.
  always_comb begin
    length_next    = length_count;
    env_level_next = envelope_level;
    env_div_next   = envelope_divider;
    case (cmd.kind)
      K_LENGTH: begin
        length_next    = channel_on ? length_lookup(cmd.data[7:3]) : '0;
        env_level_next = VOL_MAX;
        env_div_next   = volume_setting;
      end
      K_ENABLE: begin
        if (!cmd.data[0]) begin
          length_next = '0;
        end
      end
      K_FRAME: begin
        if (cmd.data[0]) begin
          if (envelope_divider == '0) begin
            env_div_next = volume_setting;
            if (envelope_level != '0) begin
              env_level_next = envelope_level - 1'b1;
            end else if (loop_halt) begin
              env_level_next = VOL_MAX;
            end
          end else begin
            env_div_next = envelope_divider - 1'b1;
          end
        end
        if (cmd.data[1] && length_count != '0 && !loop_halt) begin
          length_next = length_count - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      lfsr             <= LFSR_RESET;
      timer_count      <= '0;
      length_count     <= '0;
      envelope_level   <= '0;
      envelope_divider <= '0;
      volume_setting   <= '0;
      loop_halt        <= 1'b0;
      constant_volume  <= 1'b0;
      short_mode       <= 1'b0;
      period_select    <= '0;
      channel_on       <= 1'b0;
      m_axis_tvalid    <= 1'b0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pop) begin
            length_count     <= length_next;
            envelope_level   <= env_level_next;
            envelope_divider <= env_div_next;
            case (cmd.kind)
              K_CTRL: begin
                loop_halt       <= cmd.data[5];
                constant_volume <= cmd.data[4];
                volume_setting  <= cmd.data[3:0];
              end
              K_PERIOD: begin
                short_mode    <= cmd.data[7];
                period_select <= cmd.data[3:0];
              end
              K_ENABLE: begin
                channel_on <= cmd.data[0];
              end
              default: begin
              end
            endcase
            if (cmd.kind == K_PERIOD || cmd.kind == K_TICK) begin
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (cnt == '0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            timer_count <= rem[TIMER_W-1:0];
            state       <= ST_IDLE;
            if (pend_tick && wrapped) begin
              lfsr <= lfsr_next;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath: modulo unit, pending tick and result payload.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (pop) begin
          pend_tick   <= cmd.kind == K_TICK;
          pend_sample <= tick_sample;
          cnt         <= CNT_W'(QW - 1);
          dvs         <= D_W'(p_load) << (QW - 1);
          if (cmd.kind == K_TICK) begin
            rem <= SUM_W'(timer_count) + SUM_W'(ticks_per_sample);
          end else begin
            rem <= SUM_W'(timer_count);
          end
          out_sample <= '0;
          out_active <= length_next != '0;
        end
      end
      ST_DIV: begin
        if (rem_ge) begin
          rem <= rem - dvs[SUM_W-1:0];
        end
        dvs <= dvs >> 1;
        cnt <= cnt - 1'b1;
      end
      ST_DONE: begin
        if (out_free) begin
          out_sample <= pend_tick ? pend_sample : '0;
          out_active <= length_count != '0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* src/lfsr_noise_channel.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsr_noise_channel
// Noise voice: 15-bit LFSR on a period timer, length counter and envelope.
// ----------------------------------------------------------------------------
// Path: a request is registered in the front, held in the queue and loaded
// into the result register by the back; sample ticks and period writes first
// pass the one-bit-a-cycle restoring modulo of the timer. Throughput: one
// simple request per cycle unless the result stalls, none during a modulo.
// Reset: synchronous; all channel state to its reset values, LFSR to 1,
// ticks_per_sample to 20, no result pending.
module lfsr_noise_channel
  import lnc_pkg::*;
#(
  parameter int PERIOD_SCALE = PERIOD_SCALE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [15:0]        s_axis_tdata,  // write_value[7:0], channel_enable,
                                            // quarter_frame, half_frame, zero fill
  input  logic [3:0]         s_axis_tuser,  // operation[1:0], reg_index[3:2]
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [7:0]         m_axis_tdata,  // sample[2:0], length_active, zero fill
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [TICKS_W-1:0] cfg_data       // ticks_per_sample
);

  logic [TICKS_W-1:0] ticks_per_sample;
  logic               f_valid;
  logic               f_ready;
  cmd_t               f_cmd;
  logic               q_valid;
  logic               q_ready;
  cmd_t               q_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_sample <= TICKS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      ticks_per_sample <= cfg_data;
    end
  end

  lnc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_valid     (f_valid),
    .cmd_ready     (f_ready),
    .cmd           (f_cmd)
  );

  lnc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_cmd    (f_cmd),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_cmd   (q_cmd)
  );

  lnc_back #(
    .PERIOD_SCALE (PERIOD_SCALE)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .ticks_per_sample (ticks_per_sample),
    .cmd_valid        (q_valid),
    .cmd_ready        (q_ready),
    .cmd              (q_cmd),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata)
  );

endmodule

/* src/lnc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnc_checker
// Port-level assertions for the noise channel, bound to the top level.
// ----------------------------------------------------------------------------
module lnc_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // A held result keeps its payload until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // The amplitude table never goes above six.
  a_sample_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[2:0] != 3'd7)
    else $error("sample out of range");

  // Sound is only produced while the length counter runs.
  a_sample_gated: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[2:0] != 3'd0 |-> m_axis_tdata[3])
    else $error("sample with length counter at zero");

  // Nothing is offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule

bind lfsr_noise_channel lnc_checker u_chk (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
